### src/kfrq_pkg.sv
// ----------------------------------------------------------------------------
// kfrq_pkg
// Shared types and constants for the keyframe resync packet queue.
// ----------------------------------------------------------------------------
package kfrq_pkg;

	// Byte limit register and held byte counter widths
	localparam int LIMIT_W     = 24;
	localparam int BYTES_W     = 25;
	localparam int LIMIT_RESET = 8388608;

	// Result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_STORED  = 3'd0;
	localparam status_t ST_DROPPED = 3'd1;
	localparam status_t ST_POPPED  = 3'd2;
	localparam status_t ST_EMPTY   = 3'd3;
	localparam status_t ST_FULL    = 3'd4;

	// Request opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Control part of one result
	typedef struct packed {
		status_t              status;
		logic                 flushed;
		logic [BYTES_W-1:0]   bytes_held;
		logic                 is_video;
		logic                 is_key;
	} kfrq_res_t;

endpackage

### src/kfrq_ram.sv
// ----------------------------------------------------------------------------
// kfrq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kfrq_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/kfrq_ctrl.sv
// ----------------------------------------------------------------------------
// kfrq_ctrl
// Queue pointers, counters and resync flag; drives the descriptor RAM.
// ----------------------------------------------------------------------------
module kfrq_ctrl import kfrq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TAG_BITS    = 16,
	parameter int SIZE_BITS   = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [LIMIT_W-1:0]   byte_limit,
	input  logic                 req_take,
	input  logic                 req_opcode,
	input  logic [TAG_BITS-1:0]  req_tag,
	input  logic [SIZE_BITS-1:0] req_size,
	input  logic                 req_is_video,
	input  logic                 req_is_key,
	output logic                 busy,
	output logic                 res_valid,
	output kfrq_res_t            res,
	output logic [TAG_BITS-1:0]  res_tag,
	output logic [SIZE_BITS-1:0] res_size
);

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = TAG_BITS + SIZE_BITS + 2;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic               state_q;
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               await_q;

	logic               flush;
	logic [PTR_W-1:0]   tail_e;
	logic [CNT_W-1:0]   cnt_e;
	logic [BYTES_W-1:0] bytes_e;
	logic               await_e;
	logic               drop, full, store;
	logic [BYTES_W:0]   sum;
	logic [BYTES_W-1:0] bytes_add;
	logic [BYTES_W-1:0] pop_size;
	logic [BYTES_W-1:0] bytes_sub;
	logic               push_take, pop_take, pop_empty;
	logic               wr_en, rd_en;
	logic [ENTRY_W-1:0] wr_data, rd_data;

	logic [TAG_BITS-1:0]  rd_tag;
	logic [SIZE_BITS-1:0] rd_size;
	logic                 rd_video, rd_key;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_take = req_take && (req_opcode == OP_PUSH);
	assign pop_take  = req_take && (req_opcode == OP_POP);
	assign pop_empty = (cnt_q == '0);

	// Overflow flush is applied before the drop and full checks
	assign flush   = bytes_q > {1'b0, byte_limit};
	assign tail_e  = flush ? '0 : tail_q;
	assign cnt_e   = flush ? '0 : cnt_q;
	assign bytes_e = flush ? '0 : bytes_q;
	assign await_e = flush | await_q;

	assign drop  = req_is_video && await_e && !req_is_key;
	assign full  = (cnt_e == CNT_W'(QUEUE_DEPTH));
	assign store = !drop && !full;

	// Saturating add on store
	assign sum       = {1'b0, bytes_e} + (BYTES_W + 1)'(req_size);
	assign bytes_add = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];

	// Descriptor RAM
	assign {rd_tag, rd_size, rd_video, rd_key} = rd_data;
	assign wr_en   = push_take && store;
	assign wr_data = {req_tag, req_size, req_is_video, req_is_key};
	assign rd_en   = pop_take && !pop_empty;

	kfrq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail_e),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(head_q),
		.rd_data(rd_data)
	);

	// Saturating subtract on pop
	assign pop_size  = BYTES_W'(rd_size);
	assign bytes_sub = (bytes_q >= pop_size) ? bytes_q - pop_size : '0;

	assign busy = (state_q == S_READ);

	// Queue state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			bytes_q <= '0;
			await_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (push_take) begin
						head_q  <= flush ? '0 : head_q;
						tail_q  <= store ? next_ptr(tail_e) : tail_e;
						cnt_q   <= store ? cnt_e + 1'b1 : cnt_e;
						bytes_q <= store ? bytes_add : bytes_e;
						await_q <= store ? (await_e && !req_is_video) : await_e;
					end else if (rd_en) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					head_q  <= next_ptr(head_q);
					cnt_q   <= cnt_q - 1'b1;
					bytes_q <= bytes_sub;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result formation
	always_comb begin
		res_valid      = 1'b0;
		res.status     = ST_STORED;
		res.flushed    = 1'b0;
		res.bytes_held = bytes_q;
		res.is_video   = 1'b0;
		res.is_key     = 1'b0;
		res_tag        = '0;
		res_size       = '0;
		if (busy) begin
			res_valid      = 1'b1;
			res.status     = ST_POPPED;
			res.bytes_held = bytes_sub;
			res.is_video   = rd_video;
			res.is_key     = rd_key;
			res_tag        = rd_tag;
			res_size       = rd_size;
		end else if (push_take) begin
			res_valid      = 1'b1;
			res.flushed    = flush;
			res.status     = drop ? ST_DROPPED : (full ? ST_FULL : ST_STORED);
			res.bytes_held = store ? bytes_add : bytes_e;
		end else if (pop_take && pop_empty) begin
			res_valid  = 1'b1;
			res.status = ST_EMPTY;
		end
	end

endmodule

### src/keyframe_resync_packet_queue.sv
// ----------------------------------------------------------------------------
// keyframe_resync_packet_queue
// Byte-limited packet descriptor FIFO that flushes on overflow; after reset and
// after a flush it drops non-key video packets until a video key packet is stored.
// ----------------------------------------------------------------------------
// Timing: a push, or a pop that finds the queue empty, gives its result in the
// cycle after it is accepted, and the next request may follow at once unless the
// output stalls. A pop of a held descriptor goes through the READ state, since the
// descriptor RAM has registered read data, and the input is stalled in that state.
// The result sits in an output register, so a new request is taken in the cycle
// that the previous result leaves. The descriptor RAM needs no clearing after
// reset; the queue is usable from the first cycle.
module keyframe_resync_packet_queue import kfrq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TAG_BITS    = 16,
	parameter int SIZE_BITS   = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [LIMIT_W-1:0]   cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 opcode,
	input  logic [TAG_BITS-1:0]  pkt_tag,
	input  logic [SIZE_BITS-1:0] pkt_size,
	input  logic                 pkt_is_video,
	input  logic                 pkt_is_key,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           status,
	output logic                 flushed,
	output logic [TAG_BITS-1:0]  out_tag,
	output logic [SIZE_BITS-1:0] out_size,
	output logic                 out_is_video,
	output logic                 out_is_key,
	output logic [BYTES_W-1:0]   bytes_held
);

	logic [LIMIT_W-1:0]   byte_limit_q;
	logic                 busy;
	logic                 take;
	logic                 res_valid;
	kfrq_res_t            res;
	logic [TAG_BITS-1:0]  res_tag;
	logic [SIZE_BITS-1:0] res_size;

	logic                 out_valid_q;
	kfrq_res_t            res_q;
	logic [TAG_BITS-1:0]  tag_q;
	logic [SIZE_BITS-1:0] size_q;

	// Byte limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q <= LIMIT_W'(LIMIT_RESET);
		end else if (cfg_wr_en) begin
			byte_limit_q <= cfg_wr_data;
		end
	end

	// Request handshake
	assign in_stall = busy || (out_valid_q && out_stall);
	assign take     = in_valid && !in_stall;

	kfrq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TAG_BITS   (TAG_BITS),
		.SIZE_BITS  (SIZE_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_limit  (byte_limit_q),
		.req_take    (take),
		.req_opcode  (opcode),
		.req_tag     (pkt_tag),
		.req_size    (pkt_size),
		.req_is_video(pkt_is_video),
		.req_is_key  (pkt_is_key),
		.busy        (busy),
		.res_valid   (res_valid),
		.res         (res),
		.res_tag     (res_tag),
		.res_size    (res_size)
	);

	// Output register: loaded by a new result, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q  <= res;
			tag_q  <= res_tag;
			size_q <= res_size;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign flushed      = res_q.flushed;
	assign out_tag      = tag_q;
	assign out_size     = size_q;
	assign out_is_video = res_q.is_video;
	assign out_is_key   = res_q.is_key;
	assign bytes_held   = res_q.bytes_held;

endmodule
